// ===== rtl/core/zorder_block_address_gen_defines.svh =====
// Assertion macros used by the checker file of the address generator.
`ifndef ZORDER_BLOCK_ADDRESS_GEN_DEFINES_SVH
`define ZORDER_BLOCK_ADDRESS_GEN_DEFINES_SVH

// Check on every clock edge, reset included.
`define ZBAG_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: label");

// Check on clock edges outside reset (active-low reset).
`define ZBAG_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

`endif

// ===== rtl/core/zbag_pkg.sv =====
package zbag_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // field widths
    localparam int OP_W       = 2;
    localparam int CUIDX_W    = 18;
    localparam int ZIDX_W     = 8;
    localparam int LINE_W     = 6;
    localparam int COLS_W     = 11;
    localparam int SHIFT_W    = 3;
    localparam int LSTRIDE_W  = 14;
    localparam int CSTRIDE_W  = 13;
    localparam int LMARGIN_W  = 8;
    localparam int CMARGIN_W  = 7;
    localparam int OFFSET_W   = 26;

    // internal sum width: block term below 2^40 plus smaller terms
    localparam int TOTAL_W    = 42;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

    localparam int MAX_UNIT_BITS_DEF = 4;

    // register reset values
    localparam logic [COLS_W-1:0]    CU_COLUMNS_RST     = COLS_W'(30);
    localparam logic [SHIFT_W-1:0]   LOG2_CU_SIZE_RST   = SHIFT_W'(6);
    localparam logic [SHIFT_W-1:0]   LOG2_UNIT_SIZE_RST = SHIFT_W'(2);
    localparam logic [LSTRIDE_W-1:0] LUMA_STRIDE_RST    = LSTRIDE_W'(2064);
    localparam logic [CSTRIDE_W-1:0] CHROMA_STRIDE_RST  = CSTRIDE_W'(1032);
    localparam logic [LMARGIN_W-1:0] LUMA_MARGIN_RST    = LMARGIN_W'(72);
    localparam logic [CMARGIN_W-1:0] CHROMA_MARGIN_RST  = CMARGIN_W'(36);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CU_COLUMNS     = 3'd0,
        REG_LOG2_CU_SIZE   = 3'd1,
        REG_LOG2_UNIT_SIZE = 3'd2,
        REG_LUMA_STRIDE    = 3'd3,
        REG_CHROMA_STRIDE  = 3'd4,
        REG_LUMA_MARGIN    = 3'd5,
        REG_CHROMA_MARGIN  = 3'd6
    } t_cfg_reg;

    typedef enum logic [OP_W-1:0] {
        OP_LUMA = 2'd0,
        OP_CB   = 2'd1,
        OP_CR   = 2'd2
    } t_op;

endpackage

// ===== rtl/core/zorder_block_address_gen.sv =====
// Z-order block address generator.
// Input channel (i_in_valid / o_in_ready): one transaction per request, carrying the
// plane (operation), raster coding-block index, z-scan unit index and a luma line
// offset. Output channel (o_out_valid / i_out_ready): one transaction per request,
// in request order, with the sample offset into the plane buffer and a range flag.
// Offsets above the 26-bit range saturate with the flag set; an unknown plane code
// returns offset zero with the flag set.
// Throughput: one request per cycle while the output is not stalled. A request
// passes through the 18-step restoring divider that splits the
// block index into row and column (one quotient bit per stage), followed by
// multiply, shift, add and saturate stages.
// Configuration: write-only port, register i at index i, taken on any cycle with
// i_cfg_we high; write only while no request is in flight.
// Reset (synchronous, active low) loads the register defaults and empties the
// pipeline and output buffers.
// Receiver stall: the output register holds its transaction; one more result is
// caught in a skid register, then the whole pipeline freezes and o_in_ready drops
// until the output drains. Nothing is dropped or repeated.
module zorder_block_address_gen #(
    parameter int MAX_UNIT_BITS = zbag_pkg::MAX_UNIT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [zbag_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [zbag_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [zbag_pkg::OP_W-1:0]       i_operation,
    input  logic [zbag_pkg::CUIDX_W-1:0]    i_cu_index,
    input  logic [zbag_pkg::ZIDX_W-1:0]     i_zorder_index,
    input  logic [zbag_pkg::LINE_W-1:0]     i_line_offset,
    input  logic                            i_line_is_vertical,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [zbag_pkg::OFFSET_W-1:0]   o_sample_offset,
    output logic                            o_out_of_range
);
    import zbag_pkg::*;

    localparam int DIV_STEPS = CUIDX_W;
    localparam int BPROD_W   = CUIDX_W + LSTRIDE_W;
    localparam int UPROD_W   = MAX_UNIT_BITS + LSTRIDE_W;
    localparam int USUM_W    = UPROD_W + 1;
    localparam int LPROD_W   = LINE_W + LSTRIDE_W;
    localparam int LORIG_W   = LMARGIN_W + LSTRIDE_W + 1;
    localparam int CORIG_W   = CMARGIN_W + CSTRIDE_W + 1;

    // Divider stage: remainder builds up in rem, quotient shifts into quot.
    typedef struct packed {
        logic                     valid;
        logic [OP_W-1:0]          op;
        logic [CUIDX_W-1:0]       num;
        logic [CUIDX_W-1:0]       quot;
        logic [COLS_W-1:0]        rem;
        logic [MAX_UNIT_BITS-1:0] ux;
        logic [MAX_UNIT_BITS-1:0] uy;
        logic [LINE_W-1:0]        line;
        logic                     vert;
    } t_div_stage;

    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [LINE_W-1:0]  line;
        logic               vert;
        logic [COLS_W-1:0]  col;
        logic [BPROD_W-1:0] bprod;
        logic [USUM_W-1:0]  usum;
    } t_p1;

    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [TOTAL_W-1:0] blk;
        logic [TOTAL_W-1:0] unit;
        logic [LPROD_W-1:0] lterm;
    } t_p2;

    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [TOTAL_W-1:0] sum_bu;
        logic [TOTAL_W-1:0] org;
    } t_p3;

    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [TOTAL_W-1:0] total;
    } t_p4;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                oor;
    } t_result;

    // Unit x from the even bits, unit y from the odd bits; bits past the index read 0.
    function automatic logic [MAX_UNIT_BITS-1:0] take_bits(
        input logic [ZIDX_W-1:0] z,
        input logic              first
    );
        logic [2*ZIDX_W-1:0]      zx;
        logic [MAX_UNIT_BITS-1:0] v;
        zx = {{ZIDX_W{1'b0}}, z};
        for (int i = 0; i < MAX_UNIT_BITS; i++) begin
            v[i] = zx[2*i + int'(first)];
        end
        return v;
    endfunction

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic t_div_stage div_step(
        input t_div_stage        s,
        input logic [COLS_W-1:0] d
    );
        t_div_stage       r;
        logic [COLS_W:0]  trial;
        logic             qbit;
        r     = s;
        trial = {s.rem, s.num[CUIDX_W-1]};
        qbit  = (trial >= {1'b0, d});
        if (qbit) begin
            trial = trial - {1'b0, d};
        end
        r.rem  = trial[COLS_W-1:0];
        r.num  = {s.num[CUIDX_W-2:0], 1'b0};
        r.quot = {s.quot[CUIDX_W-2:0], qbit};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COLS_W-1:0]    r_cu_columns;
    logic [SHIFT_W-1:0]   r_log2_cu_size;
    logic [SHIFT_W-1:0]   r_log2_unit_size;
    logic [LSTRIDE_W-1:0] r_luma_stride;
    logic [CSTRIDE_W-1:0] r_chroma_stride;
    logic [LMARGIN_W-1:0] r_luma_margin;
    logic [CMARGIN_W-1:0] r_chroma_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cu_columns     <= CU_COLUMNS_RST;
            r_log2_cu_size   <= LOG2_CU_SIZE_RST;
            r_log2_unit_size <= LOG2_UNIT_SIZE_RST;
            r_luma_stride    <= LUMA_STRIDE_RST;
            r_chroma_stride  <= CHROMA_STRIDE_RST;
            r_luma_margin    <= LUMA_MARGIN_RST;
            r_chroma_margin  <= CHROMA_MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CU_COLUMNS:     r_cu_columns     <= i_cfg_data[COLS_W-1:0];
                REG_LOG2_CU_SIZE:   r_log2_cu_size   <= i_cfg_data[SHIFT_W-1:0];
                REG_LOG2_UNIT_SIZE: r_log2_unit_size <= i_cfg_data[SHIFT_W-1:0];
                REG_LUMA_STRIDE:    r_luma_stride    <= i_cfg_data[LSTRIDE_W-1:0];
                REG_CHROMA_STRIDE:  r_chroma_stride  <= i_cfg_data[CSTRIDE_W-1:0];
                REG_LUMA_MARGIN:    r_luma_margin    <= i_cfg_data[LMARGIN_W-1:0];
                REG_CHROMA_MARGIN:  r_chroma_margin  <= i_cfg_data[CMARGIN_W-1:0];
                default: ; // writes beyond the register list are dropped
            endcase
        end
    end

    // A zero column count divides as one.
    logic [COLS_W-1:0] cols;
    assign cols = (r_cu_columns == '0) ? COLS_W'(1) : r_cu_columns;

    // Plane origins are registered from the margin and stride registers and follow them in the next cycle;
    // a request needs far longer than that to reach the stage that reads them.
    logic [LMARGIN_W+LSTRIDE_W-1:0] luma_mprod;
    logic [CMARGIN_W+CSTRIDE_W-1:0] chroma_mprod;
    logic [LORIG_W-1:0]             r_luma_origin;
    logic [CORIG_W-1:0]             r_chroma_origin;

    assign luma_mprod   = r_luma_margin * r_luma_stride;
    assign chroma_mprod = r_chroma_margin * r_chroma_stride;

    always_ff @(posedge i_clk) begin
        r_luma_origin   <= {1'b0, luma_mprod} + LORIG_W'(r_luma_margin);
        r_chroma_origin <= {1'b0, chroma_mprod} + CORIG_W'(r_chroma_margin);
    end

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves as one while the skid register is empty.
    // ------------------------------------------------------------------
    logic r_skid_valid;
    logic pipe_en;

    assign pipe_en    = !r_skid_valid;
    assign o_in_ready = pipe_en;

    // ------------------------------------------------------------------
    // Divider stages: row = cu_index / cols, col = cu_index % cols
    // ------------------------------------------------------------------
    t_div_stage in_stage;
    t_div_stage n_div [DIV_STEPS];
    t_div_stage r_div [DIV_STEPS];

    always_comb begin
        in_stage.valid = i_in_valid;
        in_stage.op    = i_operation;
        in_stage.num   = i_cu_index;
        in_stage.quot  = '0;
        in_stage.rem   = '0;
        in_stage.ux    = take_bits(i_zorder_index, 1'b0);
        in_stage.uy    = take_bits(i_zorder_index, 1'b1);
        in_stage.line  = i_line_offset;
        in_stage.vert  = i_line_is_vertical;
    end

    always_comb begin
        n_div[0] = div_step(in_stage, cols);
        for (int k = 1; k < DIV_STEPS; k++) begin
            n_div[k] = div_step(r_div[k-1], cols);
        end
    end

    // ------------------------------------------------------------------
    // P1: block and unit products with the plane's stride
    // ------------------------------------------------------------------
    t_div_stage           d_last;
    logic [LSTRIDE_W-1:0] s_sel;
    logic [UPROD_W-1:0]   uprod;
    t_p1                  n_p1;
    t_p1                  r_p1;

    assign d_last = r_div[DIV_STEPS-1];
    assign s_sel  = (d_last.op == OP_LUMA) ? r_luma_stride : {1'b0, r_chroma_stride};
    assign uprod  = d_last.uy * s_sel;

    always_comb begin
        n_p1.valid = d_last.valid;
        n_p1.op    = d_last.op;
        n_p1.line  = d_last.line;
        n_p1.vert  = d_last.vert;
        n_p1.col   = d_last.rem;
        n_p1.bprod = d_last.quot * s_sel;
        n_p1.usum  = {1'b0, uprod} + USUM_W'(d_last.ux);
    end

    // ------------------------------------------------------------------
    // P2: scale block and unit terms, form the luma line term
    // ------------------------------------------------------------------
    logic [BPROD_W:0]   blk_base;
    logic [LPROD_W-1:0] lprod;
    t_p2                n_p2;
    t_p2                r_p2;

    assign blk_base = {1'b0, r_p1.bprod} + (BPROD_W+1)'(r_p1.col);
    assign lprod    = r_p1.line * r_luma_stride;

    always_comb begin
        n_p2.valid = r_p1.valid;
        n_p2.op    = r_p1.op;
        n_p2.blk   = TOTAL_W'(blk_base) << r_log2_cu_size;
        n_p2.unit  = TOTAL_W'(r_p1.usum) << r_log2_unit_size;
        n_p2.lterm = r_p1.vert ? lprod : LPROD_W'(r_p1.line);
    end

    // ------------------------------------------------------------------
    // P3: block plus unit; origin plus line (luma) or origin alone (chroma)
    // ------------------------------------------------------------------
    t_p3 n_p3;
    t_p3 r_p3;

    always_comb begin
        n_p3.valid  = r_p2.valid;
        n_p3.op     = r_p2.op;
        n_p3.sum_bu = r_p2.blk + r_p2.unit;
        if (r_p2.op == OP_LUMA) begin
            n_p3.org = TOTAL_W'(r_luma_origin) + TOTAL_W'(r_p2.lterm);
        end else begin
            n_p3.org = TOTAL_W'(r_chroma_origin);
        end
    end

    // ------------------------------------------------------------------
    // P4: final sum; chroma halves the block and unit part
    // ------------------------------------------------------------------
    t_p4 n_p4;
    t_p4 r_p4;

    always_comb begin
        n_p4.valid = r_p3.valid;
        n_p4.op    = r_p3.op;
        if (r_p3.op == OP_LUMA) begin
            n_p4.total = r_p3.org + r_p3.sum_bu;
        end else begin
            n_p4.total = r_p3.org + (r_p3.sum_bu >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_div[k].valid <= 1'b0;
            end
            r_p1.valid <= 1'b0;
            r_p2.valid <= 1'b0;
            r_p3.valid <= 1'b0;
            r_p4.valid <= 1'b0;
        end else if (pipe_en) begin
            r_div <= n_div;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_p4  <= n_p4;
        end
    end

    // ------------------------------------------------------------------
    // Saturate and flag, then output register with one-entry skid
    // ------------------------------------------------------------------
    t_result fmt;

    always_comb begin
        if (r_p4.op != OP_LUMA && r_p4.op != OP_CB && r_p4.op != OP_CR) begin
            // unknown plane code
            fmt.offset = '0;
            fmt.oor    = 1'b1;
        end else if (r_p4.total > TOTAL_W'(OFFSET_MAX)) begin
            fmt.offset = OFFSET_MAX;
            fmt.oor    = 1'b1;
        end else begin
            fmt.offset = r_p4.total[OFFSET_W-1:0];
            fmt.oor    = 1'b0;
        end
    end

    logic    r_out_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;
    logic    pipe_leave;

    assign out_free   = !r_out_valid || i_out_ready;
    assign pipe_leave = pipe_en && r_p4.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // refill the output from the skid first; the pipe is frozen meanwhile
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= pipe_leave;
            end
        end else if (pipe_leave) begin
            // receiver stalled: catch the result leaving the pipe
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : fmt;
        end
        if (!out_free && pipe_leave) begin
            r_skid <= fmt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_offset = r_out.offset;
    assign o_out_of_range  = r_out.oor;

endmodule

// ===== rtl/core/zbag_checker.sv =====
`include "zorder_block_address_gen_defines.svh"

module zbag_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [zbag_pkg::OFFSET_W-1:0] o_sample_offset,
    input logic                          o_out_of_range
);
    import zbag_pkg::*;

    // reset leaves no result pending and the input open
    `ZBAG_ASSERT(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)

    // a stalled result holds its value
    `ZBAG_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_offset) && $stable(o_out_of_range))

    // a flagged result is either saturated or the unknown-plane zero
    `ZBAG_ASSERT_RST(a_flag_value, i_clk, i_rst_n, o_out_valid && o_out_of_range |-> o_sample_offset == OFFSET_MAX || o_sample_offset == '0)

    // input backpressure only while a result waits at the output
    `ZBAG_ASSERT_RST(a_ready_cause, i_clk, i_rst_n, !o_in_ready |-> o_out_valid)

endmodule

bind zorder_block_address_gen zbag_checker u_zbag_checker (.*);
